// File: sv/pcbp_pkg.sv
`default_nettype none

package pcbp_pkg;

  // field widths
  localparam int unsigned SYM_W   = 8;
  localparam int unsigned CODE_W  = 32;
  localparam int unsigned LEN_W   = 6;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned DEPTH   = 1 << SYM_W;

  // longest code accepted on load, saturated to the table width
  localparam int unsigned MAX_CODE_LEN = 32;
  localparam int unsigned LEN_CAP = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

  // pack buffer: up to seven pending bits plus one full code
  localparam int unsigned BUF_W = CODE_W + BYTE_W;
  localparam int unsigned CNT_W = 6;
  localparam int unsigned SHF_W = 3;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_ENCODE = 2'd1,
    ACT_FLUSH  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  // table entry: code left aligned, first bit in the msb
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } entry_t;

endpackage

`default_nettype wire

// File: sv/prefix_code_bit_packer_top.sv
`default_nettype none

// channel  | dir | payload                                          | beat
// in_      | in  | action, symbol, code_bits, code_length           | one load, encode or flush
// out_     | out | out_byte, out_last                               | one packed byte
//
// the buffer stage takes no new item until the single byte output register
// has drained every whole byte of the last one from the 40-bit pack buffer,
// one byte per cycle while out_stall is low.
// the code table memory is read in the accept cycle into a registered read port.
// rst_n is synchronous and clears control state; the table is not cleared.
// out_stall holds the output register; in_stall rises while the buffer stage
// still owes bytes and an encode or flush waits in front of it.

module prefix_code_bit_packer_top
  import pcbp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        in_action,
  input  wire logic [SYM_W-1:0]  in_symbol,
  input  wire logic [CODE_W-1:0] in_code_bits,
  input  wire logic [LEN_W-1:0]  in_code_length,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [BYTE_W-1:0]      out_byte,
  output logic                   out_last
);

  // code table memory
  entry_t mem [DEPTH];
  entry_t rd_q_r;

  // lookup stage
  logic s1_v_r, s1_v_nxt;
  logic s1_flush_r, s1_flush_nxt;

  // pack buffer stage
  logic [BUF_W-1:0] buf_r, buf_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             flush_r, flush_nxt;

  // output register
  logic              out_v_r, out_v_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic              out_last_r, out_last_nxt;

  action_t          act;
  logic             in_acc;
  logic             s1_take;
  logic             out_free;
  logic             emit;
  logic [LEN_W-1:0] len_eff;
  logic [2*CODE_W-1:0] align_w;
  entry_t           wr_ent;
  logic [BUF_W-1:0] merge_w;

  assign act = action_t'(in_action);

  // buffer takes a new item only when no whole byte or flush is owed
  assign s1_take  = (cnt_r < CNT_W'(BYTE_W)) && !flush_r;
  assign in_stall = s1_v_r && !s1_take;
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_v_r || !out_stall;
  assign emit     = out_free && (flush_r || (cnt_r >= CNT_W'(BYTE_W)));

  // load path: saturate length and left align the code
  always_comb begin
    if (in_code_length > LEN_W'(LEN_CAP)) begin
      len_eff = LEN_W'(LEN_CAP);
    end else begin
      len_eff = in_code_length;
    end
    align_w     = {in_code_bits, {CODE_W{1'b0}}} >> len_eff;
    wr_ent.code = align_w[CODE_W-1:0];
    wr_ent.len  = len_eff;
  end

  // table write on load, registered read on encode
  always_ff @(posedge clk) begin
    if (in_acc && act == ACT_LOAD) begin
      mem[in_symbol] <= wr_ent;
    end
    if (in_acc && act == ACT_ENCODE) begin
      rd_q_r <= mem[in_symbol];
    end
  end

  // lookup stage control
  always_comb begin
    s1_v_nxt     = s1_v_r;
    s1_flush_nxt = s1_flush_r;
    if (s1_v_r && s1_take) begin
      s1_v_nxt = 1'b0;
    end
    if (in_acc) begin
      unique case (act)
        ACT_ENCODE: begin
          s1_v_nxt     = 1'b1;
          s1_flush_nxt = 1'b0;
        end
        ACT_FLUSH: begin
          s1_v_nxt     = 1'b1;
          s1_flush_nxt = 1'b1;
        end
        ACT_LOAD, ACT_NONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  // merge new code behind the pending bits
  assign merge_w = buf_r | ({rd_q_r.code, {BYTE_W{1'b0}}} >> cnt_r[SHF_W-1:0]);

  // pack buffer and output register
  always_comb begin
    buf_nxt      = buf_r;
    cnt_nxt      = cnt_r;
    flush_nxt    = flush_r;
    out_v_nxt    = out_v_r;
    out_byte_nxt = out_byte_r;
    out_last_nxt = out_last_r;
    if (out_v_r && !out_stall) begin
      out_v_nxt = 1'b0;
    end
    if (emit) begin
      out_v_nxt    = 1'b1;
      out_byte_nxt = buf_r[BUF_W-1 -: BYTE_W];
      if (flush_r) begin
        out_last_nxt = 1'b1;
        buf_nxt      = '0;
        cnt_nxt      = '0;
        flush_nxt    = 1'b0;
      end else begin
        out_last_nxt = (cnt_r < CNT_W'(2*BYTE_W));
        buf_nxt      = buf_r << BYTE_W;
        cnt_nxt      = cnt_r - CNT_W'(BYTE_W);
      end
    end else if (s1_v_r && s1_take) begin
      if (s1_flush_r) begin
        flush_nxt = 1'b1;
      end else begin
        buf_nxt = merge_w;
        cnt_nxt = cnt_r + CNT_W'(rd_q_r.len);
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      buf_r   <= '0;
      cnt_r   <= '0;
      flush_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      buf_r   <= buf_nxt;
      cnt_r   <= cnt_nxt;
      flush_r <= flush_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    s1_flush_r <= s1_flush_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_v_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule

`default_nettype wire

// File: sv/pcbp_checker.sv
`default_nettype none

module pcbp_checker
  import pcbp_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [BYTE_W-1:0] out_byte,
  input wire logic              out_last
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("stalled output beat changed");

  // reset empties the output register
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // reset empties the lookup stage
  a_rst_in: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("input stalled after reset");

  // bytes of one item leave back to back once taken
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=> out_valid)
    else $error("gap inside an item's bytes");

endmodule

bind prefix_code_bit_packer_top pcbp_checker u_pcbp_checker (.*);

`default_nettype wire

// File: tb/prefix_code_bit_packer_top_tb.sv
module prefix_code_bit_packer_top_tb
  import pcbp_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned HOLD_OFF_CYCLES = 300;

  // one packed output byte as the block should emit it
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } packed_byte_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [1:0]          in_action = ACT_NONE;
  logic [SYM_W-1:0]    in_symbol = '0;
  logic [CODE_W-1:0]   in_code_bits = '0;
  logic [LEN_W-1:0]    in_code_length = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [BYTE_W-1:0]   out_byte;
  logic                out_last;

  // shadow copy of the code table and the bit accumulator
  logic [CODE_W-1:0]   shadow_code [DEPTH];
  logic [LEN_W-1:0]    shadow_len [DEPTH];
  bit                  sym_loaded [DEPTH];
  int unsigned         loaded_syms [$];
  logic [BYTE_W-1:0]   acc_bits = '0;
  int unsigned         acc_count = 0;

  // bytes the block still owes, oldest first
  packed_byte_t        owed_bytes [$];
  int unsigned         error_count = 0;

  int unsigned         send_idle_pct = 0;
  int unsigned         stall_pct = 0;
  int unsigned         hold_cycles = 0;

  prefix_code_bit_packer_top u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_symbol      (in_symbol),
    .in_code_bits   (in_code_bits),
    .in_code_length (in_code_length),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_last       (out_last)
  );

  always #4 clk = ~clk;

  // receiver: long hold-off when requested, random stalls otherwise
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // compare every accepted output beat with the oldest owed byte
  always @(posedge clk) begin
    packed_byte_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (owed_bytes.size() == 0) begin
        $error("unexpected output beat: out_byte 0x%02h out_last %0b", out_byte, out_last);
        error_count++;
      end else begin
        want = owed_bytes.pop_front();
        if (out_byte !== want.data) begin
          $error("out_byte mismatch: expected 0x%02h, actual 0x%02h", want.data, out_byte);
          error_count++;
        end
        if (out_last !== want.last) begin
          $error("out_last mismatch: expected %0b, actual %0b", want.last, out_last);
          error_count++;
        end
      end
    end
  end

  // append one byte to the owed list
  task automatic owe_byte(input logic [BYTE_W-1:0] data, input logic last);
    packed_byte_t nb;
    nb.data = data;
    nb.last = last;
    owed_bytes = {owed_bytes, nb};
  endtask

  // update the shadow state for one accepted beat and queue the bytes it yields
  task automatic pack_beat(input action_t act, input logic [SYM_W-1:0] sym,
                           input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len);
    int unsigned n_bytes;
    int unsigned bit_len;
    logic [CODE_W-1:0] word;
    n_bytes = 0;
    case (act)
      ACT_LOAD: begin
        shadow_code[sym] = code;
        shadow_len[sym] = (len > LEN_CAP) ? LEN_W'(LEN_CAP) : len;
        if (!sym_loaded[sym]) begin
          sym_loaded[sym] = 1'b1;
          loaded_syms = {loaded_syms, 32'(sym)};
        end
      end
      ACT_ENCODE: begin
        word = shadow_code[sym];
        bit_len = 32'(shadow_len[sym]);
        // shift code in msb first, emit each full byte
        for (int i = int'(bit_len); i > 0; i--) begin
          acc_bits = {acc_bits[BYTE_W-2:0], word[i-1]};
          acc_count++;
          if (acc_count == BYTE_W) begin
            owe_byte(acc_bits, 1'b0);
            acc_bits = '0;
            acc_count = 0;
            n_bytes++;
          end
        end
        if (n_bytes > 0) owed_bytes[$].last = 1'b1;
      end
      ACT_FLUSH: begin
        // pad pending bits with zeros on the right; empty flush gives zero
        owe_byte(BYTE_W'(acc_bits << (BYTE_W - acc_count)), 1'b1);
        acc_bits = '0;
        acc_count = 0;
      end
      default: ;
    endcase
  endtask

  // offer one beat, with random idle cycles ahead of it
  task automatic send_beat(input action_t act, input logic [SYM_W-1:0] sym,
                           input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_symbol <= sym;
    in_code_bits <= code;
    in_code_length <= len;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pack_beat(act, sym, code, len);
  endtask

  // sender goes quiet until every owed byte has arrived
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (owed_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // extremes of every field, all actions and the corner cases
  task automatic test_directed();
    send_idle_pct = 0;
    stall_pct <= 0;
    send_beat(ACT_LOAD, 8'd0, 32'hFFFF_FFFF, 6'd32);
    send_beat(ACT_LOAD, 8'd255, 32'h0000_0000, 6'd63);
    send_beat(ACT_LOAD, 8'd1, 32'h0000_0005, 6'd3);
    send_beat(ACT_LOAD, 8'd2, 32'hA5A5_A5A5, 6'd0);
    send_beat(ACT_LOAD, 8'd3, 32'h0000_0001, 6'd1);
    send_beat(ACT_LOAD, 8'd4, 32'h0000_00AB, 6'd8);
    send_beat(ACT_LOAD, 8'd5, 32'h8000_0001, 6'd33);
    // unknown action must leave the table and accumulator alone
    send_beat(ACT_NONE, 8'd1, 32'hFFFF_FFFF, 6'd63);
    send_beat(ACT_FLUSH, 8'd0, 32'h0, 6'd0);
    send_beat(ACT_ENCODE, 8'd0, 32'h0, 6'd0);
    send_beat(ACT_ENCODE, 8'd1, 32'h0, 6'd0);
    send_beat(ACT_ENCODE, 8'd0, 32'h0, 6'd0);
    send_beat(ACT_ENCODE, 8'd255, 32'h0, 6'd0);
    send_beat(ACT_ENCODE, 8'd2, 32'h0, 6'd0);
    send_beat(ACT_ENCODE, 8'd3, 32'h0, 6'd0);
    send_beat(ACT_FLUSH, 8'd255, 32'hFFFF_FFFF, 6'd63);
    send_beat(ACT_ENCODE, 8'd4, 32'h0, 6'd0);
    send_beat(ACT_FLUSH, 8'd0, 32'h0, 6'd0);
    send_beat(ACT_ENCODE, 8'd1, 32'h0, 6'd0);
    send_beat(ACT_ENCODE, 8'd1, 32'h0, 6'd0);
    send_beat(ACT_ENCODE, 8'd3, 32'h0, 6'd0);
    send_beat(ACT_ENCODE, 8'd5, 32'h0, 6'd0);
    send_beat(ACT_FLUSH, 8'd0, 32'h0, 6'd0);
    wait_drained();
  endtask

  // receiver holds off while long codes keep coming, so the input backs up
  task automatic test_receiver_holdoff();
    send_idle_pct = 0;
    stall_pct <= 0;
    send_beat(ACT_LOAD, 8'd7, CODE_W'($urandom), 6'd32);
    hold_cycles <= HOLD_OFF_CYCLES;
    for (int i = 0; i < 30; i++) begin
      send_beat(ACT_ENCODE, 8'd7, CODE_W'($urandom), LEN_W'($urandom));
    end
    send_beat(ACT_ENCODE, 8'd3, 32'h0, 6'd0);
    send_beat(ACT_FLUSH, 8'd0, 32'h0, 6'd0);
    while (hold_cycles != 0) @(posedge clk);
    wait_drained();
  endtask

  // mostly encodes of loaded symbols, with loads, flushes and some noise
  task automatic test_random_phase(input int unsigned idle_pct, input int unsigned stall,
                                   input int unsigned count);
    int unsigned sent;
    int unsigned pick;
    int unsigned len_pick;
    logic [LEN_W-1:0] len;
    send_idle_pct = idle_pct;
    stall_pct <= stall;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 3) begin
        send_beat(ACT_NONE, SYM_W'($urandom), CODE_W'($urandom), LEN_W'($urandom));
      end else begin
        if (loaded_syms.size() < 4 || pick < 18) begin
          len_pick = $urandom_range(99);
          if (len_pick < 5) len = '0;
          else if (len_pick < 70) len = LEN_W'($urandom_range(12, 1));
          else if (len_pick < 90) len = LEN_W'($urandom_range(32, 13));
          else len = LEN_W'($urandom_range(63, 33));
          send_beat(ACT_LOAD, SYM_W'($urandom), CODE_W'($urandom), len);
        end else if (pick < 26) begin
          send_beat(ACT_FLUSH, SYM_W'($urandom), CODE_W'($urandom), LEN_W'($urandom));
        end else begin
          send_beat(ACT_ENCODE,
                    SYM_W'(loaded_syms[$urandom_range(loaded_syms.size() - 1)]),
                    CODE_W'($urandom), LEN_W'($urandom));
        end
        sent++;
      end
    end
    wait_drained();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_receiver_holdoff();
    test_random_phase(0, 0, 90);
    test_random_phase(45, 0, 90);
    test_random_phase(0, 45, 90);
    test_random_phase(27, 27, 90);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
